[sv/bfspa_pkg.sv]
// Shared types, codes and constants for the best-fit split page allocator.
package bfspa_pkg;

    localparam int ADDR_W          = 32;
    localparam int SIZE_W          = 21;
    localparam int SPL_W           = 5;
    localparam int STATUS_W        = 3;
    localparam int IN_TDATA_W      = 56;
    localparam int OUT_TDATA_W     = 32;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 32;
    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_PAGE_BYTES  = 4096;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_REGION_BASE  = 1'b0,
        REG_REGION_PAGES = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic    in_ready;
        logic    load;
        logic    init_wr;
        logic    scan_clear;
        logic    scan_step;
        logic    count_init;
        logic    count_step;
        logic    mul;
        logic    split_wr;
        logic    final_wr;
        logic    free_wr;
        logic    set_res;
        logic    res_base;
        status_t res_status;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic init_pend;
        logic op_free;
        logic zero_req;
        logic scan_last;
        logic found;
        logic halve_ok;
        logic full;
        logic split_ok;
        logic out_busy;
    } dp_status_t;

endpackage

[sv/bfspa_dp.sv]
// Datapath: block table memory, scan, split arithmetic and result registers.
module bfspa_dp #(
    parameter int MAX_BLOCKS = bfspa_pkg::DEF_MAX_BLOCKS,
    parameter int PAGE_BYTES = bfspa_pkg::DEF_PAGE_BYTES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bfspa_pkg::dp_cmd_t                    cmd,
    output bfspa_pkg::dp_status_t                 status,
    input  logic                                  in_op,
    input  logic [bfspa_pkg::IN_TDATA_W-1:0]      in_data,
    input  logic                                  cfg_valid,
    input  logic [bfspa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bfspa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [bfspa_pkg::OUT_TDATA_W-1:0]     out_data,
    output logic [bfspa_pkg::STATUS_W-1:0]        out_user
);
    import bfspa_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = ((CNT_W > SPL_W) ? CNT_W : SPL_W) + 1;
    localparam logic [ADDR_W-1:0] PAGE_MUL = ADDR_W'(PAGE_BYTES);
    localparam logic [SUM_W-1:0]  SUM_MAX  = SUM_W'(MAX_BLOCKS);

    logic [ADDR_W-1:0] mem_start [MAX_BLOCKS];
    logic [SIZE_W-1:0] mem_size  [MAX_BLOCKS];
    logic              mem_used  [MAX_BLOCKS];

    logic [ADDR_W-1:0] region_base_reg;
    logic [SIZE_W-1:0] region_pages_reg;
    logic              init_pend_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              rd_v_reg;
    logic              found_reg;
    logic              out_valid_reg;

    op_t               op_reg;
    logic [SIZE_W-1:0] n_reg;
    logic [ADDR_W-1:0] fa_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ADDR_W-1:0] rd_start_reg;
    logic [SIZE_W-1:0] rd_size_reg;
    logic              rd_used_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SIZE_W-1:0] best_size_reg;
    logic [ADDR_W-1:0] best_start_reg;
    logic [SIZE_W-1:0] s_reg;
    logic [SPL_W-1:0]  splits_reg;
    logic [SIZE_W-1:0] old_reg;
    logic [SIZE_W-1:0] half_reg;
    logic [ADDR_W-1:0] prod_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    status_t           res_status_reg;
    logic [ADDR_W-1:0] out_data_reg;
    status_t           out_user_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ADDR_W-1:0] wr_start;
    logic [SIZE_W-1:0] wr_size;
    logic              wr_used;
    logic              hit_alloc;
    logic              hit_free;
    logic              hit;
    logic [SUM_W-1:0]  sum_total;

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = best_idx_reg;
        wr_start = best_start_reg;
        wr_size  = best_size_reg;
        wr_used  = 1'b0;
        if (cmd.init_wr)
        begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_start = region_base_reg;
            wr_size  = region_pages_reg;
        end
        else if (cmd.split_wr)
        begin
            wr_en    = 1'b1;
            wr_addr  = total_reg[IDX_W-1:0];
            wr_start = best_start_reg + prod_reg;
            wr_size  = old_reg - half_reg;
        end
        else if (cmd.final_wr)
        begin
            wr_en   = 1'b1;
            wr_size = old_reg;
            wr_used = 1'b1;
        end
        else if (cmd.free_wr)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_addr] <= wr_start;
            mem_size[wr_addr]  <= wr_size;
            mem_used[wr_addr]  <= wr_used;
        end
        rd_start_reg <= mem_start[cnt_reg[IDX_W-1:0]];
        rd_size_reg  <= mem_size[cnt_reg[IDX_W-1:0]];
        rd_used_reg  <= mem_used[cnt_reg[IDX_W-1:0]];
    end

    assign hit_alloc = !rd_used_reg && (rd_size_reg >= n_reg)
                       && (!found_reg || (rd_size_reg < best_size_reg));
    assign hit_free  = (rd_start_reg == fa_reg) && !found_reg;
    assign hit       = rd_v_reg && ((op_reg == OP_FREE) ? hit_free : hit_alloc);
    assign sum_total = SUM_W'(total_reg) + SUM_W'(splits_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg  <= '0;
            region_pages_reg <= SIZE_W'(1024);
            init_pend_reg    <= 1'b1;
            total_reg        <= CNT_W'(1);
            cnt_reg          <= '0;
            rd_v_reg         <= 1'b0;
            found_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_REGION_BASE)
                begin
                    region_base_reg <= cfg_data;
                end
                else
                begin
                    region_pages_reg <= cfg_data[SIZE_W-1:0];
                end
                init_pend_reg <= 1'b1;
            end
            else if (cmd.init_wr)
            begin
                init_pend_reg <= 1'b0;
            end

            if (cmd.init_wr)
            begin
                total_reg <= CNT_W'(1);
            end
            else if (cmd.split_wr)
            begin
                total_reg <= total_reg + CNT_W'(1);
            end

            if (cmd.scan_clear)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            rd_v_reg <= cmd.scan_step;

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_reg[IDX_W-1:0];
        if (cmd.load)
        begin
            op_reg <= op_t'(in_op);
            n_reg  <= in_data[SIZE_W-1:0];
            fa_reg <= in_data[SIZE_W +: ADDR_W];
        end
        if (hit)
        begin
            best_idx_reg   <= rd_idx_reg;
            best_size_reg  <= rd_size_reg;
            best_start_reg <= rd_start_reg;
        end
        if (cmd.count_init)
        begin
            s_reg      <= best_size_reg;
            splits_reg <= '0;
            old_reg    <= best_size_reg;
            half_reg   <= best_size_reg >> 1;
        end
        else
        begin
            if (cmd.count_step)
            begin
                s_reg      <= s_reg >> 1;
                splits_reg <= splits_reg + SPL_W'(1);
            end
            if (cmd.split_wr)
            begin
                old_reg  <= half_reg;
                half_reg <= half_reg >> 1;
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= ADDR_W'(half_reg) * PAGE_MUL;
        end
        if (cmd.set_res)
        begin
            res_addr_reg   <= cmd.res_base ? best_start_reg : '0;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= res_addr_reg;
            out_user_reg <= res_status_reg;
        end
    end

    assign status.init_pend = init_pend_reg;
    assign status.op_free   = (op_reg == OP_FREE);
    assign status.zero_req  = (n_reg == '0);
    assign status.scan_last = (cnt_reg == (total_reg - CNT_W'(1)));
    assign status.found     = found_reg;
    assign status.halve_ok  = ((s_reg >> 1) >= n_reg);
    assign status.full      = (sum_total > SUM_MAX);
    assign status.split_ok  = (half_reg >= n_reg);
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

[sv/bfspa_ctrl.sv]
// Controller state machine: sequences scan, split count, splits and the response.
module bfspa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  bfspa_pkg::dp_status_t status,
    output bfspa_pkg::dp_cmd_t    cmd
);
    import bfspa_pkg::*;

    typedef enum logic [7:0]
    {
        S_IDLE     = 8'b0000_0001,
        S_SCAN     = 8'b0000_0010,
        S_SCAN_END = 8'b0000_0100,
        S_CHECK    = 8'b0000_1000,
        S_COUNT    = 8'b0001_0000,
        S_MUL      = 8'b0010_0000,
        S_WR       = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (status.init_pend)
                begin
                    cmd.init_wr = 1'b1;
                end
                else
                begin
                    cmd.in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load       = 1'b1;
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (!status.op_free && status.zero_req)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_ZERO;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = S_SCAN_END;
                    end
                end
            end
            S_SCAN_END:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.op_free)
                begin
                    cmd.set_res = 1'b1;
                    state_next  = S_RESP;
                    if (status.found)
                    begin
                        cmd.free_wr    = 1'b1;
                        cmd.res_status = ST_OK;
                    end
                    else
                    begin
                        cmd.res_status = ST_NOTFOUND;
                    end
                end
                else if (!status.found)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOFIT;
                    state_next     = S_RESP;
                end
                else
                begin
                    cmd.count_init = 1'b1;
                    state_next     = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (status.halve_ok)
                begin
                    cmd.count_step = 1'b1;
                end
                else if (status.full)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_RESP;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (status.split_ok)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_WR;
                end
                else
                begin
                    cmd.final_wr   = 1'b1;
                    cmd.set_res    = 1'b1;
                    cmd.res_base   = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_RESP;
                end
            end
            S_WR:
            begin
                cmd.split_wr = 1'b1;
                state_next   = S_MUL;
            end
            S_RESP:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/best_fit_split_page_allocator.sv]
// Top level of the best-fit split page allocator.
//
//  channel   direction  handshake                word contents (low bit first)
//  s_axis    in         s_axis_tvalid/tready     tdata: page_count, free_address; tuser: op
//  m_axis    out        m_axis_tvalid/tready     tdata: block_address; tuser: status
//  cfg       in         cfg_valid/cfg_ready      cfg_index: register, cfg_data: value
//
//  A free or an allocate answers after a one-entry-per-cycle scan of the table memory; a
//  successful allocate then counts its splits and runs the multiply-then-write step of
//  each split. A zero-page allocate answers without a scan. One word is in work at a time.
//  After reset and after each cfg write, table entry 0 is rewritten before the next word
//  is accepted. A stalled result does not block the next accept.
module best_fit_split_page_allocator #(
    parameter int MAX_BLOCKS = bfspa_pkg::DEF_MAX_BLOCKS,
    parameter int PAGE_BYTES = bfspa_pkg::DEF_PAGE_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bfspa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // page_count, free_address
    input  logic                               s_axis_tuser,  // operation
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [bfspa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // block_address
    output logic [bfspa_pkg::STATUS_W-1:0]     m_axis_tuser,  // status
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bfspa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bfspa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bfspa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bfspa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    bfspa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

    assign s_axis_tready = cmd.in_ready;
    assign cfg_ready     = 1'b1;

    a_split_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split_wr |-> $past(cmd.mul))
        else $error("split write without a preceding product");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while one is in work");

    a_error_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
        else $error("error result carries a nonzero address");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the best-fit split page allocator with predicted replies.
module testbench;
    import bfspa_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_BLOCKS;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [SIZE_W-1:0] MAX_PAGES = SIZE_W'(1048576);
    localparam logic [ADDR_W-1:0] TOP_BASE = 32'hFFFF_F000;

    typedef struct
    {
        logic [ADDR_W-1:0] addr;
        status_t           status;
    } alloc_reply_t;

    typedef struct
    {
        bit                is_cfg;
        reg_index_t        reg_sel;
        logic [ADDR_W-1:0] reg_value;
        op_t               op;
        logic [SIZE_W-1:0] pages;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        alloc_reply_t      want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata;   // page_count, free_address
    logic                      s_axis_tuser;   // operation
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;   // block_address
    logic [STATUS_W-1:0]       m_axis_tuser;   // status
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    logic [ADDR_W-1:0] seg_start [TABLE_DEPTH];
    logic [SIZE_W-1:0] seg_pages [TABLE_DEPTH];
    bit                seg_taken [TABLE_DEPTH];
    int                seg_count;
    logic [ADDR_W-1:0] region_base_q;
    logic [SIZE_W-1:0] region_pages_q;

    alloc_reply_t pending_replies[$];
    plan_row_t    plan[$];
    int           fault_count;
    bit           calm;
    bit           hold_req;

    best_fit_split_page_allocator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void rebuild_table();
        int i;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            seg_start[i] = '0;
            seg_pages[i] = '0;
            seg_taken[i] = 1'b0;
        end
        seg_start[0] = region_base_q;
        seg_pages[0] = region_pages_q;
        seg_count = 1;
    endfunction

    function automatic alloc_reply_t predict_reply(op_t op, logic [SIZE_W-1:0] n,
                                                   logic [ADDR_W-1:0] fa);
        alloc_reply_t      r;
        int                i;
        int                best;
        int                splits;
        int                s;
        int                old;
        int                half;
        logic [ADDR_W-1:0] base;
        r.addr = '0;
        r.status = ST_OK;
        if (op == OP_FREE)
        begin
            for (i = 0; i < seg_count; i++)
            begin
                if (seg_start[i] == fa)
                begin
                    seg_taken[i] = 1'b0;
                    return r;
                end
            end
            r.status = ST_NOTFOUND;
            return r;
        end
        if (n == '0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        best = -1;
        for (i = 0; i < seg_count; i++)
        begin
            if (!seg_taken[i] && seg_pages[i] >= n
                && (best < 0 || seg_pages[i] < seg_pages[best]))
                best = i;
        end
        if (best < 0)
        begin
            r.status = ST_NOFIT;
            return r;
        end
        splits = 0;
        s = int'(seg_pages[best]);
        while (s / 2 >= int'(n))
        begin
            s = s / 2;
            splits++;
        end
        if (seg_count + splits > TABLE_DEPTH)
        begin
            r.status = ST_FULL;
            return r;
        end
        base = seg_start[best];
        old = int'(seg_pages[best]);
        half = old / 2;
        while (half >= int'(n))
        begin
            seg_pages[best] = SIZE_W'(half);
            seg_start[seg_count] = base + ADDR_W'(longint'(half) * DEF_PAGE_BYTES);
            seg_pages[seg_count] = SIZE_W'(old - half);
            seg_taken[seg_count] = 1'b0;
            seg_count++;
            old = half;
            half = half / 2;
        end
        seg_taken[best] = 1'b1;
        r.addr = base;
        return r;
    endfunction

    function automatic plan_row_t mk_item(op_t op, logic [SIZE_W-1:0] pages,
                                          logic [ADDR_W-1:0] addr, bit typed,
                                          logic [ADDR_W-1:0] want_addr, status_t want_status);
        plan_row_t w;
        w.is_cfg = 1'b0;
        w.reg_sel = REG_REGION_BASE;
        w.reg_value = '0;
        w.op = op;
        w.pages = pages;
        w.addr = addr;
        w.typed = typed;
        w.want.addr = want_addr;
        w.want.status = want_status;
        return w;
    endfunction

    function automatic plan_row_t mk_cfg(reg_index_t sel, logic [ADDR_W-1:0] value);
        plan_row_t w;
        w = mk_item(OP_ALLOC, '0, '0, 1'b0, '0, ST_OK);
        w.is_cfg = 1'b1;
        w.reg_sel = sel;
        w.reg_value = value;
        return w;
    endfunction

    task automatic send_word(plan_row_t w);
        int           gap;
        alloc_reply_t r;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, w.addr, w.pages};
        s_axis_tuser <= w.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = predict_reply(w.op, w.pages, w.addr);
        if (w.typed)
            pending_replies.push_back(w.want);
        else
            pending_replies.push_back(r);
    endtask

    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t sel, logic [ADDR_W-1:0] value);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (sel == REG_REGION_BASE)
            region_base_q = value;
        else
            region_pages_q = value[SIZE_W-1:0];
        rebuild_table();
        @(posedge clk);
    endtask

    task automatic send_random_word();
        int                roll;
        int                span;
        logic [SIZE_W-1:0] n;
        roll = $urandom_range(0, 99);
        span = 0;
        while (span < 20 && (1 << span) < int'(region_pages_q))
            span++;
        if (roll < 55)
        begin
            n = SIZE_W'($urandom_range(1, 1 << $urandom_range(0, span)));
            send_word(mk_item(OP_ALLOC, n, $urandom, 1'b0, '0, ST_OK));
        end
        else if (roll < 85)
            send_word(mk_item(OP_FREE, SIZE_W'($urandom),
                              seg_start[$urandom_range(0, seg_count - 1)], 1'b0, '0, ST_OK));
        else if (roll < 90)
            send_word(mk_item(OP_FREE, SIZE_W'($urandom), $urandom, 1'b0, '0, ST_OK));
        else if (roll < 95)
            send_word(mk_item(OP_ALLOC, SIZE_W'($urandom_range(0, 1048576)), $urandom,
                              1'b0, '0, ST_OK));
        else
        begin
            case ($urandom_range(0, 2))
                0: n = '0;
                1: n = MAX_PAGES;
                default: n = region_pages_q;
            endcase
            send_word(mk_item(OP_ALLOC, n, $urandom, 1'b0, '0, ST_OK));
        end
    endtask

    always @(posedge clk)
    begin : reply_check
        alloc_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected word: addr %h status %0d", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tdata !== want.addr || m_axis_tuser !== want.status)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                                 want.addr, want.status, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    initial
    begin : reply_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int        i;
        int        phase;
        int        count;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] pages;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fault_count = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        region_base_q = '0;
        region_pages_q = SIZE_W'(1024);
        rebuild_table();

        plan.push_back(mk_item(OP_ALLOC, '0, '0, 1'b1, '0, ST_ZERO));
        plan.push_back(mk_item(OP_FREE, '0, '0, 1'b1, '0, ST_OK));
        plan.push_back(mk_item(OP_FREE, '1, '1, 1'b1, '0, ST_NOTFOUND));
        plan.push_back(mk_item(OP_ALLOC, MAX_PAGES, '0, 1'b1, '0, ST_NOFIT));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1025), '0, 1'b1, '0, ST_NOFIT));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1024), '0, 1'b1, '0, ST_OK));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1), '0, 1'b1, '0, ST_NOFIT));
        plan.push_back(mk_item(OP_FREE, '0, '0, 1'b1, '0, ST_OK));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1), '0, 1'b1, '0, ST_OK));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1), '0, 1'b0, '0, ST_OK));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(512), '0, 1'b0, '0, ST_OK));
        plan.push_back(mk_cfg(REG_REGION_PAGES, 32'(MAX_PAGES)));
        plan.push_back(mk_cfg(REG_REGION_BASE, TOP_BASE));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1), '0, 1'b1, TOP_BASE, ST_OK));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(2), '0, 1'b0, '0, ST_OK));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(524288), '0, 1'b0, '0, ST_OK));
        plan.push_back(mk_item(OP_FREE, '0, '0, 1'b0, '0, ST_OK));
        plan.push_back(mk_cfg(REG_REGION_PAGES, '0));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1), '0, 1'b1, '0, ST_NOFIT));
        plan.push_back(mk_item(OP_FREE, '0, TOP_BASE, 1'b1, '0, ST_OK));
        plan.push_back(mk_cfg(REG_REGION_PAGES, 32'd1));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1), '0, 1'b1, TOP_BASE, ST_OK));
        plan.push_back(mk_item(OP_ALLOC, SIZE_W'(1), '0, 1'b1, '0, ST_NOFIT));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_sel, plan[i].reg_value);
            else
                send_word(plan[i]);
        end

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    base = '0;
                    pages = 32'd1024;
                end
                1:
                begin
                    base = TOP_BASE;
                    pages = 32'(MAX_PAGES);
                end
                2:
                begin
                    base = $urandom & TOP_BASE;
                    pages = $urandom_range(1, 64);
                end
                3:
                begin
                    base = $urandom & TOP_BASE;
                    pages = $urandom_range(1, 1048576);
                end
                4:
                begin
                    base = $urandom & TOP_BASE;
                    pages = 32'd1;
                end
                default:
                begin
                    base = '0;
                    pages = $urandom_range(2, 4096);
                end
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_REGION_BASE, base);
                write_reg(REG_REGION_PAGES, pages);
            end
            else
            begin
                write_reg(REG_REGION_PAGES, pages);
                write_reg(REG_REGION_BASE, base);
            end
            calm = (phase == 3);
            count = (phase == 4) ? 40 : 142;
            for (i = 0; i < count; i++)
            begin
                if (phase == 2 && i == 5)
                    hold_req = 1'b1;
                send_random_word();
            end
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[best_fit_split_page_allocator.f]
sv/bfspa_pkg.sv
sv/bfspa_dp.sv
sv/bfspa_ctrl.sv
sv/best_fit_split_page_allocator.sv
dv/testbench.sv
